// ===== rtl/core/rit_pkg.sv =====
// Shared types and constants for the repeating interval timer.
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

  // Field widths.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Register reset values.
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [TIME_W-1:0] REPEATS_RESET  = 32'd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 1'b0,
    CFG_REPEATS  = 1'b1
  } cfg_idx_t;

  // Operation codes carried by each request.
  typedef enum logic [OP_W-1:0] {
    OP_CHECK      = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_RESET      = 3'd3,
    OP_SET_TARGET = 3'd4
  } op_t;

  // Timer state.
  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_EXPIRED = 2'd2
  } timer_state_t;

  // Status after one request, handed from the state unit to the output stage.
  typedef struct packed {
    logic              fired;
    logic              running;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] saved;
    logic [TIME_W-1:0] rem_rep;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/core/rit_state.sv =====
// Timer state registers, configuration registers and per-request update logic.
`timescale 1ns / 1ps
`default_nettype none

module rit_state (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic [rit_pkg::OP_W-1:0]      op,
  input  wire logic [rit_pkg::TIME_W-1:0]    now,
  input  wire logic [rit_pkg::TIME_W-1:0]    time_arg,
  input  wire logic                          cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rit_pkg::TIME_W-1:0]    cfg_data,
  output rit_pkg::step_t                     step
);
  import rit_pkg::*;

  timer_state_t      state_r, state_nxt;
  logic [TIME_W-1:0] target_r, target_nxt;
  logic [TIME_W-1:0] rep_r, rep_nxt;
  logic [TIME_W-1:0] saved_r, saved_nxt;
  logic [TIME_W-1:0] interval_r;
  logic [TIME_W-1:0] repeats_r;
  logic              fired;
  logic [TIME_W-1:0] add_a, add_b, add_sum;
  logic              reached;

  // One shared adder: the check path advances the target, start loads it.
  assign add_a   = (op == OP_CHECK) ? target_r : time_arg;
  assign add_b   = (op == OP_START && saved_r != '0) ? saved_r : interval_r;
  assign add_sum = add_a + add_b;
  assign reached = (now >= target_r);

  // Next state for the request in the input register.
  always_comb begin
    state_nxt  = state_r;
    target_nxt = target_r;
    rep_nxt    = rep_r;
    saved_nxt  = saved_r;
    fired      = 1'b0;
    unique case (op)
      OP_CHECK: begin
        if (state_r == ST_RUNNING && reached) begin
          fired = 1'b1;
          if (rep_r != TIME_W'(1)) begin
            if (rep_r != '0) begin
              rep_nxt = rep_r - TIME_W'(1);
            end
            target_nxt = add_sum;
          end else begin
            state_nxt = ST_EXPIRED;
          end
        end
      end
      OP_START: begin
        state_nxt  = ST_RUNNING;
        target_nxt = add_sum;
        saved_nxt  = '0;
      end
      OP_STOP: begin
        state_nxt = ST_STOPPED;
        if (!reached) begin
          saved_nxt = target_r - now;
        end
      end
      OP_RESET: begin
        state_nxt = ST_STOPPED;
        saved_nxt = '0;
        rep_nxt   = repeats_r;
      end
      OP_SET_TARGET: begin
        target_nxt = time_arg;
      end
      default: begin
      end
    endcase
  end

  // Status after the request; an expired timer on its last repeat shows zero.
  always_comb begin
    step.fired   = fired;
    step.running = (state_nxt == ST_RUNNING);
    step.now     = now;
    step.target  = target_nxt;
    step.saved   = saved_nxt;
    step.rem_rep = (state_nxt == ST_EXPIRED && rep_nxt == TIME_W'(1)) ? '0 : rep_nxt;
  end

  // State/config registers. User writes only while the block is idle; unenforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_STOPPED;
      target_r   <= '0;
      rep_r      <= '0;
      saved_r    <= '0;
      interval_r <= INTERVAL_RESET;
      repeats_r  <= REPEATS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_REPEATS: begin
          repeats_r <= cfg_data;
          rep_r     <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (step_en) begin
      state_r  <= state_nxt;
      target_r <= target_nxt;
      rep_r    <= rep_nxt;
      saved_r  <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/repeating_interval_timer_core.sv =====
// Top level of the repeating interval timer: input register, state unit, output register.
`timescale 1ns / 1ps
`default_nettype none

// Each request on the in_ channel carries an operation (check, start, stop,
// reset, set target), the current time and a time argument. Every request
// produces exactly one result on the out_ channel: fired, running, remaining
// time, remaining repeats and target time, in request order.
// The request is captured in an input register. The state unit updates the
// timer as the request leaves that register, and the remaining time is formed
// on the same path into the output register. A result passes the input register
// and then the output register, and with no stall one request can be accepted
// every cycle; the state update loop sets that rate.
// The input register moves when the output register is empty or draining,
// so a request is still taken while a result waits as long as the input
// register is free. A stall on out_ holds the result, and once the input
// register also holds a request in_stall rises.
// The user writes interval and repeats on the cfg_ port only while idle; the block
// does not enforce it. Writing repeats also reloads the repeat counter. Synchronous
// reset empties the registers, stops and clears the timer and restores interval 1000.
module repeating_interval_timer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rit_pkg::OP_W-1:0]      in_operation,
  input  wire logic [rit_pkg::TIME_W-1:0]    in_now,
  input  wire logic [rit_pkg::TIME_W-1:0]    in_time_arg,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_fired,
  output logic                               out_running,
  output logic [rit_pkg::TIME_W-1:0]         out_remaining_time,
  output logic [rit_pkg::TIME_W-1:0]         out_remaining_repeats,
  output logic [rit_pkg::TIME_W-1:0]         out_target_time,
  input  wire logic                          cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rit_pkg::TIME_W-1:0]    cfg_data
);
  import rit_pkg::*;

  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [TIME_W-1:0] s1_arg_r;
  step_t             step;
  logic              out_valid_r;
  logic              out_ready, s1_ready;
  logic              s1_move;

  // Handshake: the input register moves when the output register can take data.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_ready;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_op_r  <= in_operation;
      s1_now_r <= in_now;
      s1_arg_r <= in_time_arg;
    end
  end

  // Timer state update, committed as the request leaves the input register.
  rit_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_move),
    .op        (s1_op_r),
    .now       (s1_now_r),
    .time_arg  (s1_arg_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step)
  );

  // Output register with the remaining time formed on the way in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_fired             <= step.fired;
      out_running           <= step.running;
      out_remaining_time    <= step.running ? (step.target - step.now) : step.saved;
      out_remaining_repeats <= step.rem_rep;
      out_target_time       <= step.target;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/rit_checker.sv =====
// Port-level checks for the repeating interval timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rit_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_fired,
  input wire logic                          out_running,
  input wire logic [rit_pkg::TIME_W-1:0]    out_remaining_time,
  input wire logic [rit_pkg::TIME_W-1:0]    out_remaining_repeats,
  input wire logic [rit_pkg::TIME_W-1:0]    out_target_time
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_target_time)
      && $stable(out_remaining_time) && $stable(out_remaining_repeats)
      && $stable(out_fired) && $stable(out_running))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the output register empty the block can always take a request.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // A firing that stops the timer is the last repeat, shown as zero left.
  a_last_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired && !out_running |-> out_remaining_repeats == '0)
    else $error("expiring fire with repeats left");

endmodule

bind repeating_interval_timer_core rit_checker u_rit_checker (.*);

`default_nettype wire

// ===== dv/tb_repeating_interval_timer_core.sv =====
// Self-checking testbench for the repeating interval timer core.
`timescale 1ns / 1ps

module tb_repeating_interval_timer_core;
  import rit_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;
  // Extra settling margin used after draining and at the end of the run.
  localparam int unsigned PIPE_LATENCY = 1;
  localparam int unsigned PHASE_COUNT  = 12;
  localparam int unsigned PHASE_ITEMS  = 125;

  // One result as seen on the out_ channel.
  typedef struct packed {
    logic              fired;
    logic              running;
    logic [TIME_W-1:0] remaining_time;
    logic [TIME_W-1:0] remaining_repeats;
    logic [TIME_W-1:0] target_time;
  } timer_result_t;

  // Timer predictor plus the queue of results it expects, in request order.
  class timer_scoreboard;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] repeats;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] repeat_left;
    logic [TIME_W-1:0] saved;
    timer_state_t      state;
    timer_result_t     expected_q[$];
    int unsigned       errors;

    function new();
      interval    = INTERVAL_RESET;
      repeats     = REPEATS_RESET;
      target      = '0;
      repeat_left = '0;
      saved       = '0;
      state       = ST_STOPPED;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [TIME_W-1:0] value);
      case (idx)
        CFG_INTERVAL: begin
          interval = value;
        end
        CFG_REPEATS: begin
          repeats     = value;
          repeat_left = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Apply one accepted request to the predicted timer and queue its result.
    function void note_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                               logic [TIME_W-1:0] arg);
      timer_result_t r;
      r = '0;
      case (op)
        OP_CHECK: begin
          if (state == ST_RUNNING && now >= target) begin
            if (repeat_left != 1) begin
              if (repeat_left != 0) repeat_left = repeat_left - 1;
              target = target + interval;
            end else begin
              state = ST_EXPIRED;
            end
            r.fired = 1'b1;
          end
        end
        OP_START: begin
          state = ST_RUNNING;
          if (saved != 0) begin
            target = arg + saved;
            saved  = '0;
          end else begin
            target = arg + interval;
          end
        end
        OP_STOP: begin
          state = ST_STOPPED;
          // Time left is only kept while the target is still ahead.
          if (now < target) saved = target - now;
        end
        OP_RESET: begin
          state       = ST_STOPPED;
          saved       = '0;
          repeat_left = repeats;
        end
        OP_SET_TARGET: begin
          target = arg;
        end
        default: begin
        end
      endcase
      r.running           = (state == ST_RUNNING);
      r.remaining_time    = (state == ST_RUNNING) ? target - now : saved;
      r.remaining_repeats = (state == ST_EXPIRED && repeat_left == 1) ? '0 : repeat_left;
      r.target_time       = target;
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(timer_result_t got);
      timer_result_t want;
      string         bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request pending: fired=%0b run=%0b rem_t=%h rem_r=%h tgt=%h",
                   $time, got.fired, got.running, got.remaining_time,
                   got.remaining_repeats, got.target_time);
        return;
      end
      want = expected_q.pop_front();
      bad  = "";
      if (got.fired !== want.fired) bad = {bad, " fired"};
      if (got.running !== want.running) bad = {bad, " running"};
      if (got.remaining_time !== want.remaining_time) bad = {bad, " remaining_time"};
      if (got.remaining_repeats !== want.remaining_repeats) bad = {bad, " remaining_repeats"};
      if (got.target_time !== want.target_time) bad = {bad, " target_time"};
      if (bad != "") begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch in%s", $time, bad);
          $display("  exp fired=%0b run=%0b rem_t=%h rem_r=%h tgt=%h", want.fired,
                   want.running, want.remaining_time, want.remaining_repeats,
                   want.target_time);
          $display("  got fired=%0b run=%0b rem_t=%h rem_r=%h tgt=%h", got.fired,
                   got.running, got.remaining_time, got.remaining_repeats,
                   got.target_time);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [TIME_W-1:0] in_now;
  logic [TIME_W-1:0] in_time_arg;
  logic              out_valid;
  logic              out_stall;
  logic              out_fired;
  logic              out_running;
  logic [TIME_W-1:0] out_remaining_time;
  logic [TIME_W-1:0] out_remaining_repeats;
  logic [TIME_W-1:0] out_target_time;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [TIME_W-1:0] cfg_data;

  timer_scoreboard sb;
  // Sender pacing: quiet stretches have no gaps, push phases keep offering.
  bit              tx_quiet;
  bit              tx_push;
  bit              long_hold_req;
  int unsigned     requests_sent;

  repeating_interval_timer_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_now               (in_now),
    .in_time_arg          (in_time_arg),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_fired            (out_fired),
    .out_running          (out_running),
    .out_remaining_time   (out_remaining_time),
    .out_remaining_repeats(out_remaining_repeats),
    .out_target_time      (out_target_time),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Gap after a request: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_quiet || tx_push) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, wait for it to be taken, then idle for a random gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_v,
                              input logic [TIME_W-1:0] arg_v);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_now       <= now_v;
    in_time_arg  <= arg_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, now_v, arg_v);
    requests_sent++;
    if (requests_sent % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [TIME_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed runs (start, then checks as time moves on, with
  // stops, resumes, retargets and resets mixed in), plus random noise.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       run_len;
    int unsigned       span;
    logic [TIME_W-1:0] t;
    sent = 0;
    t    = $urandom;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 3) begin
        send_request(OP_W'($urandom_range(0, 2**OP_W - 1)), $urandom, $urandom);
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0) t = $urandom;
        span = (sb.interval == 0 || sb.interval > 2000) ? 2000 : sb.interval;
        send_request(OP_START, t, t);
        sent++;
        run_len = $urandom_range(3, 24);
        repeat (run_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            t += $urandom_range(0, span);
            send_request(OP_CHECK, t, $urandom);
          end else if (pick < 72) begin
            // Land just before, on or just after the predicted target.
            t = sb.target + $urandom_range(0, 2) - 1;
            send_request(OP_CHECK, t, $urandom);
          end else if (pick < 80) begin
            t += $urandom_range(0, span);
            send_request(OP_STOP, t, $urandom);
            t += $urandom_range(0, span);
            send_request(OP_START, t, t);
            sent++;
          end else if (pick < 87) begin
            send_request(OP_SET_TARGET, t, t + $urandom_range(0, span));
          end else if (pick < 92) begin
            send_request(OP_RESET, t, $urandom);
          end else begin
            send_request(OP_START, t, t);
          end
          sent++;
        end
      end
    end
  endtask

  // Receiver: checks accepted results and stalls at random.
  initial begin : result_sink
    int unsigned   hold_left;
    int unsigned   mode_left;
    bit            rx_quiet;
    timer_result_t got;
    hold_left = 0;
    mode_left = 0;
    rx_quiet  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_fired, out_running, out_remaining_time, out_remaining_repeats,
               out_target_time};
        sb.check_result(got);
      end
      if (mode_left == 0) begin
        rx_quiet  = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 200);
      end else begin
        mode_left--;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = $urandom_range(120, 200);
      end else if (hold_left == 0 && !rx_quiet && $urandom_range(0, 99) < 25) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence: reset, directed requests, then randomized phases.
  initial begin : stimulus
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] rp;
    sb            = new();
    tx_quiet      = 1'b0;
    tx_push       = 1'b0;
    long_hold_req = 1'b0;
    requests_sent = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= '0;
    in_now       <= '0;
    in_time_arg  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_INTERVAL;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset settings: check while stopped, unused codes,
    // firing, stop with time left and resume, stop past target, wrapping sum.
    send_request(OP_CHECK, '0, '0);
    for (int c = OP_SET_TARGET + 1; c < 2**OP_W; c++) send_request(OP_W'(c), '1, '1);
    send_request(OP_START, '0, '0);
    send_request(OP_CHECK, 32'd999, '0);
    send_request(OP_CHECK, 32'd1000, '0);
    send_request(OP_STOP, 32'd1500, '0);
    send_request(OP_CHECK, 32'd1600, '0);
    send_request(OP_START, 32'd3000, 32'd3000);
    send_request(OP_STOP, 32'd4000, '0);
    send_request(OP_SET_TARGET, 32'd4000, '1);
    send_request(OP_START, '1, '1);
    send_request(OP_CHECK, '1, '0);
    send_request(OP_RESET, '0, '0);
    drain();

    // Directed with a finite count: fire down to expired, then reload.
    write_reg(CFG_INTERVAL, 32'd10);
    write_reg(CFG_REPEATS, 32'd2);
    send_request(OP_START, 32'd100, 32'd100);
    send_request(OP_CHECK, 32'd110, '0);
    send_request(OP_CHECK, 32'd125, '0);
    send_request(OP_CHECK, 32'd200, '0);
    send_request(OP_STOP, 32'd200, '0);
    send_request(OP_RESET, 32'd200, '0);
    send_request(OP_START, 32'd5, 32'd5);
    send_request(OP_SET_TARGET, '0, '0);
    send_request(OP_CHECK, '0, '0);
    drain();

    // Randomized phases over a spread of settings, extremes included.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin iv = 32'd1000;          rp = 32'd0;                     end
        1:       begin iv = 32'd0;             rp = 32'd3;                     end
        2:       begin iv = 32'd1;             rp = 32'd1;                     end
        3:       begin iv = '1;                rp = 32'd2;                     end
        4:       begin iv = 32'd7;             rp = '1;                        end
        5:       begin iv = $urandom_range(2, 300);   rp = $urandom_range(1, 5);  end
        6:       begin iv = $urandom_range(1, 2000);  rp = 32'd0;               end
        7:       begin iv = 32'd50;            rp = 32'd1;                     end
        8:       begin iv = $urandom;          rp = $urandom;                  end
        9:       begin iv = 32'd0;             rp = 32'd0;                     end
        10:      begin iv = $urandom_range(100, 1000); rp = $urandom_range(2, 10); end
        default: begin iv = INTERVAL_RESET;    rp = REPEATS_RESET;             end
      endcase
      write_reg(CFG_INTERVAL, iv);
      write_reg(CFG_REPEATS, rp);
      // Some phases hold the receiver off while requests keep coming.
      tx_push = (p % 4 == 1);
      if (tx_push) long_hold_req = 1'b1;
      run_random_phase(PHASE_ITEMS);
      tx_push = 1'b0;
      drain();
    end

    repeat (PIPE_LATENCY + 6) @(posedge clk);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rit_pkg.sv
rtl/core/rit_state.sv
rtl/core/repeating_interval_timer_core.sv
rtl/core/rit_checker.sv
dv/tb_repeating_interval_timer_core.sv
